/* rtl/pli_pkg.sv */
// Shared types and constants for the percentile interpolation block.
package pli_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int P_W      = 14;
  localparam int P_FULL   = 10000;
  localparam int P_RESET  = 5000;
  localparam int RES_W    = 32;
  localparam int PROD_W   = P_W + SAMPLE_W;
  localparam int DIV_W    = PROD_W + FRAC_W;

  // flips the sign bit so signed order becomes unsigned order
  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] percentile_q16;
    logic                    status;
  } out_word_t;

  typedef struct packed {
    logic done;
    logic busy;
  } unit_stat_t;

endpackage

/* rtl/pli_div.sv */
// Divider by the fixed percentile scale, by reciprocal multiplication in two halves.
module pli_div
  import pli_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output unit_stat_t       stat,
  output logic [DIV_W-1:0] quotient,
  output logic [P_W-1:0]   remainder
);

  // P_FULL = 625 * 16: the low four bits pass straight into the remainder
  localparam int LOW_W  = 4;
  localparam int HALF_W = (DIV_W - LOW_W) / 2;
  localparam int D_W    = 10;
  localparam int OP_W   = D_W + HALF_W;
  localparam int MUL_W  = 2 * OP_W;
  localparam int SH     = 40;
  localparam logic [D_W-1:0]  DIV_D   = D_W'(P_FULL >> LOW_W);
  // ceil(2**40 / 625): the floor is exact for any operand below 2**31
  localparam logic [OP_W-1:0] RECIP_M = OP_W'(1759218605);

  logic               busy;
  logic               done;
  logic               fix;
  logic               lo_pass;
  logic [OP_W-1:0]    op;
  logic [HALF_W-1:0]  low_half;
  logic [LOW_W-1:0]   low_bits;
  logic [HALF_W-1:0]  q_hi;
  logic [MUL_W-1:0]   prod;
  logic [DIV_W-1:0]   q_out;
  logic [P_W-1:0]     r_out;
  logic [HALF_W-1:0]  q_est;
  logic [OP_W-1:0]    q_times_d;
  logic [D_W-1:0]     r_est;

  // both passes keep the quotient below 2**21
  assign q_est     = prod[SH +: HALF_W];
  assign q_times_d = OP_W'(q_est) * OP_W'(DIV_D);
  assign r_est     = D_W'(op - q_times_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        fix      <= 1'b0;
        lo_pass  <= 1'b0;
        op       <= OP_W'(dividend[DIV_W-1 -: HALF_W]);
        low_half <= dividend[LOW_W +: HALF_W];
        low_bits <= dividend[LOW_W-1:0];
      end else if (busy) begin
        if (!fix) begin
          prod <= MUL_W'(op) * MUL_W'(RECIP_M);
          fix  <= 1'b1;
        end else if (!lo_pass) begin
          // upper half done: its remainder heads the lower half
          q_hi    <= q_est;
          op      <= {r_est, low_half};
          fix     <= 1'b0;
          lo_pass <= 1'b1;
        end else begin
          q_out <= DIV_W'({q_hi, q_est});
          r_out <= {r_est, low_bits};
          busy  <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign stat      = '{done: done, busy: busy};
  assign quotient  = q_out;
  assign remainder = r_out;

endmodule

/* rtl/pli_sel.sv */
// Sample memory and bitwise k-th smallest selection over it.
module pli_sel
  import pli_pkg::*;
#(
  parameter int MAX_SAMPLES = 256,
  localparam int IW = $clog2(MAX_SAMPLES),
  localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  sample_t       wr_data,
  input  logic          start,
  input  logic [IW-1:0] k,
  input  logic [CW-1:0] n,
  output unit_stat_t    stat,
  output sample_t       value
);

  localparam int BW = $clog2(SAMPLE_W);

  typedef enum logic [2:0] {
    SL_IDLE   = 3'b001,
    SL_SCAN   = 3'b010,
    SL_DECIDE = 3'b100
  } sel_state_t;

  sel_state_t          state;
  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_v;
  logic [CW-1:0]       addr;
  logic [CW-1:0]       cnt;
  logic [IW-1:0]       kk;
  logic [BW-1:0]       bitpos;
  logic [SAMPLE_W-1:0] prefix;
  logic                done;
  logic                issue;
  logic                hit;
  logic [SAMPLE_W-1:0] mask;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[addr[IW-1:0]];
  end

  assign issue = (state == SL_SCAN) && (addr < n);
  assign mask  = {SAMPLE_W{1'b1}} << bitpos;
  assign hit   = (((rd_data ^ SIGN_FLIP ^ prefix) & mask) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SL_IDLE;
      rd_v  <= 1'b0;
      done  <= 1'b0;
    end else begin
      rd_v <= issue;
      done <= 1'b0;
      unique case (state)
        SL_IDLE: begin
          if (start) begin
            prefix <= '0;
            bitpos <= BW'(SAMPLE_W - 1);
            kk     <= k;
            cnt    <= '0;
            addr   <= '0;
            state  <= SL_SCAN;
          end
        end
        SL_SCAN: begin
          if (issue) begin
            addr <= addr + 1'b1;
          end
          if (rd_v && hit) begin
            cnt <= cnt + 1'b1;
          end
          if (!issue && !rd_v) begin
            state <= SL_DECIDE;
          end
        end
        SL_DECIDE: begin
          // enough matches below: the bit stays 0, else skip past them
          if (CW'(kk) >= cnt) begin
            prefix[bitpos] <= 1'b1;
            kk             <= IW'(CW'(kk) - cnt);
          end
          cnt  <= '0;
          addr <= '0;
          if (bitpos == '0) begin
            done  <= 1'b1;
            state <= SL_IDLE;
          end else begin
            bitpos <= bitpos - 1'b1;
            state  <= SL_SCAN;
          end
        end
        default: state <= SL_IDLE;
      endcase
    end
  end

  assign stat  = '{done: done, busy: (state != SL_IDLE)};
  assign value = sample_t'(prefix ^ SIGN_FLIP);

endmodule

/* rtl/percentile_linear_interp.sv */
// Top level: percentile of a sample set by linear interpolation between ranks.
//
// Input channel (in_valid/in_ready, in_data): one signed 16-bit sample per word,
// the final word of a set carrying last. Samples load one per cycle, in the load state, into an
// on-chip store of MAX_SAMPLES entries; words beyond that are dropped and the
// set's result carries status = 1. A dropped last word still closes the set.
// Output channel (out_valid/out_ready, out_data): one word per set, the value in
// signed Q16.16 plus the status bit.
// Config: cfg_we writes cfg_wdata into the percentile register (hundredths of a
// percent, above 10000 treated as 10000). Write only while the block is idle.
// Processing: after last, the block runs a rank selection (one memory scan per
// sample bit: n reads, emptying the read pipe, then a decide step), once or
// twice, plus two reciprocal-multiply divisions and its control states. No input
// is taken during that time.
// The result sits in an output register; the next set may load while it waits.
// If the receiver still stalls when the next result is ready, the block holds.
// Reset (rst, synchronous): empty set, no result pending, percentile 5000.
module percentile_linear_interp
  import pli_pkg::*;
#(
  parameter int MAX_SAMPLES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_word_t       in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output out_word_t      out_data,
  input  logic           cfg_we,
  input  logic [P_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int NW = P_W + CW;

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_IDX    = 9'b000000010,
    S_DIV1   = 9'b000000100,
    S_SEL_LO = 9'b000001000,
    S_SEL_HI = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_TERM   = 9'b001000000,
    S_DIV2   = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t            state;
  logic [P_W-1:0]    pct;
  logic [CW-1:0]     count;
  logic              overflow;
  logic [CW-1:0]     n_reg;
  logic              ovf_reg;
  logic [IW-1:0]     lo_idx;
  logic [P_W-1:0]    rem_reg;
  sample_t           lo_val;
  sample_t           hi_val;
  logic [PROD_W-1:0] prod;
  logic [RES_W-1:0]  res;

  logic              acc;
  logic              full;
  logic              wr_en;
  logic              out_load;
  logic [P_W-1:0]    p_sat;
  logic [CW-1:0]     nm1;
  logic [NW-1:0]     num;
  logic [SAMPLE_W:0] diff;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  unit_stat_t        div_stat;
  logic [DIV_W-1:0]  div_q;
  logic [P_W-1:0]    div_r;

  logic              sel_start;
  logic [IW-1:0]     sel_k;
  unit_stat_t        sel_stat;
  sample_t           sel_value;

  // ---- input side ----
  assign in_ready = (state == S_LOAD);
  assign acc      = in_valid && in_ready;
  assign full     = (count == CW'(MAX_SAMPLES));
  assign wr_en    = acc && !full;

  // ---- output side: load when the register is free or being emptied ----
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // ---- rank: p*(n-1) split into index and remainder by the divider ----
  assign p_sat = (pct > P_W'(P_FULL)) ? P_W'(P_FULL) : pct;
  assign nm1   = n_reg - 1'b1;
  assign num   = NW'(p_sat) * NW'(nm1);

  // hi >= lo always, so the difference fits unsigned in SAMPLE_W bits
  assign diff  = {lo_val[SAMPLE_W-1], lo_val} - {lo_val[SAMPLE_W-1], lo_val} +
                 {hi_val[SAMPLE_W-1], hi_val} - {lo_val[SAMPLE_W-1], lo_val};

  assign div_start    = (state == S_IDX) || (state == S_TERM);
  assign div_dividend = (state == S_IDX) ? DIV_W'(num) : {prod, {FRAC_W{1'b0}}};

  // second selection only when the rank has a fractional part
  assign sel_start = ((state == S_DIV1) && div_stat.done) ||
                     ((state == S_SEL_LO) && sel_stat.done && (rem_reg != '0));
  assign sel_k     = (state == S_DIV1) ? div_q[IW-1:0] : IW'(lo_idx + 1'b1);

  pli_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  pli_sel #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_sel (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (count[IW-1:0]),
    .wr_data (in_data.sample),
    .start   (sel_start),
    .k       (sel_k),
    .n       (n_reg),
    .stat    (sel_stat),
    .value   (sel_value)
  );

  // ---- config ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= P_W'(P_RESET);
    end else if (cfg_we) begin
      pct <= cfg_wdata;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (acc) begin
            if (in_data.last) begin
              n_reg    <= full ? count : CW'(count + 1'b1);
              ovf_reg  <= overflow || full;
              count    <= '0;
              overflow <= 1'b0;
              state    <= S_IDX;
            end else if (!full) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
          end
        end
        S_IDX: begin
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (div_stat.done) begin
            lo_idx  <= div_q[IW-1:0];
            rem_reg <= div_r;
            state   <= S_SEL_LO;
          end
        end
        S_SEL_LO: begin
          if (sel_stat.done) begin
            lo_val <= sel_value;
            if (rem_reg != '0) begin
              state <= S_SEL_HI;
            end else begin
              hi_val <= sel_value;
              state  <= S_MUL;
            end
          end
        end
        S_SEL_HI: begin
          if (sel_stat.done) begin
            hi_val <= sel_value;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(rem_reg) * PROD_W'(diff[SAMPLE_W-1:0]);
          state <= S_TERM;
        end
        S_TERM: begin
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_stat.done) begin
            // fraction term is floored by the divider, always non-negative
            res   <= {lo_val, {FRAC_W{1'b0}}} + div_q[RES_W-1:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_data <= '{percentile_q16: res, status: ovf_reg};
            state    <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // ---- checks ----
  a_no_write_during_select: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !sel_stat.busy)
    else $error("sample store written while a selection scan runs");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a division wait");

  a_sel_done_expected: assert property (@(posedge clk) disable iff (rst)
    sel_stat.done |-> (state == S_SEL_LO || state == S_SEL_HI))
    else $error("selection finished outside a selection wait");

  a_set_restarts: assert property (@(posedge clk) disable iff (rst)
    (acc && in_data.last) |=> (count == '0 && !overflow))
    else $error("set not cleared after its last word");

endmodule

/* sim/pli_checker.sv */
// Result checker for the percentile block: mirrors its state, predicts each result, compares.
`timescale 1ns / 100ps
module pli_result_checker
  import pli_pkg::*;
#(
  parameter int MAX_SAMPLES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  in_word_t       in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  out_word_t      out_data,
  input  logic           cfg_we,
  input  logic [P_W-1:0] cfg_wdata,
  output int             mismatch_count,
  output int             outstanding
);

  sample_t        held [MAX_SAMPLES];
  int             held_n;
  logic           dropped;
  logic [P_W-1:0] pct_reg;
  out_word_t      pending_percentiles [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  // sort the held set, pick the two ranks, interpolate in Q16 with floor rounding
  function automatic out_word_t predict_percentile();
    int        ord [MAX_SAMPLES];
    int        i, j, key, p, lo_idx, hi_idx;
    longint    num, rem, lo, hi, prod, term, res;
    out_word_t w;
    for (i = 0; i < held_n; i++) ord[i] = held[i];
    for (i = 1; i < held_n; i++) begin
      key = ord[i];
      j = i;
      while (j > 0 && ord[j-1] > key) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    p = (pct_reg > P_FULL) ? P_FULL : int'(pct_reg);
    num = longint'(p) * longint'(held_n - 1);
    lo_idx = int'(num / P_FULL);
    rem = num % P_FULL;
    hi_idx = (rem != 0) ? lo_idx + 1 : lo_idx;
    if (hi_idx >= held_n) hi_idx = held_n - 1;
    lo = ord[lo_idx];
    hi = ord[hi_idx];
    prod = rem * (hi - lo) * 65536;
    term = (prod >= 0) ? prod / P_FULL : -((-prod + P_FULL - 1) / P_FULL);
    res = lo * 65536 + term;
    w.percentile_q16 = res[31:0];
    w.status = dropped;
    return w;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      held_n  = 0;
      dropped = 1'b0;
      pct_reg = P_RESET;
      pending_percentiles.delete();
    end else begin
      if (cfg_we) pct_reg = cfg_wdata;
      // results first, so a word leaving now never meets an expectation made now
      if (out_valid && out_ready) begin
        if (pending_percentiles.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result word with none expected, value %0d status %0b",
                     $time, out_data.percentile_q16, out_data.status);
        end else begin
          want = pending_percentiles.pop_front();
          if (out_data.percentile_q16 !== want.percentile_q16)
            note_mismatch("percentile_q16", want.percentile_q16, out_data.percentile_q16);
          if (out_data.status !== want.status)
            note_mismatch("status", want.status, out_data.status);
        end
      end
      if (in_valid && in_ready) begin
        if (held_n < MAX_SAMPLES) begin
          held[held_n] = in_data.sample;
          held_n++;
        end else begin
          dropped = 1'b1;
        end
        if (in_data.last) begin
          pending_percentiles.push_back(predict_percentile());
          held_n  = 0;
          dropped = 1'b0;
        end
      end
    end
    outstanding = pending_percentiles.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for percentile_linear_interp: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps
module tb_top;
  import pli_pkg::*;

  localparam int CAPACITY = 256;
  // cycles with no word moving on either channel before the run is declared hung
  localparam int WATCHDOG = 40000;
  localparam int PHASE_WORDS = 30;

  // how a set's samples are spread
  typedef enum int {SPREAD_FULL, SPREAD_EDGES, SPREAD_NARROW} spread_e;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  in_word_t       in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  out_word_t      out_data;
  logic           cfg_we = 1'b0;
  logic [P_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int outstanding;
  int idle_cycles = 0;
  bit steady = 1'b0;   // set for phases run with no idling on either side

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  percentile_linear_interp #(
    .MAX_SAMPLES(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  pli_result_checker #(
    .MAX_SAMPLES(CAPACITY)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  // Hang detection: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: ready may drop before each word (never in steady phases), then holds until it moves.
  // A zero draw keeps ready high straight through to the next word.
  initial begin
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // One sample word. Called at a rising edge; returns at the edge that took the word,
  // leaving valid high so a back-to-back word needs no second assignment that step.
  task automatic send_word(input sample_t s, input bit fin);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.sample <= s;
    in_data.last   <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic sample_t pick_sample(input spread_e spread);
    int v;
    case (spread)
      SPREAD_EDGES: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      SPREAD_NARROW: v = $urandom_range(0, 8) - 4;  // lots of ties
      default: v = $urandom_range(0, 65535);
    endcase
    return sample_t'(v);
  endfunction

  // n words, last flag on the final one; beyond CAPACITY the block drops them
  task automatic send_set(input int n);
    spread_e spread;
    case ($urandom_range(0, 5))
      0, 1, 2: spread = SPREAD_FULL;
      3:       spread = SPREAD_EDGES;
      default: spread = SPREAD_NARROW;
    endcase
    for (int k = 0; k < n; k++) send_word(pick_sample(spread), k == n - 1);
  endtask

  // Mostly short sets, now and then a medium one; every set closes with last.
  task automatic run_sets(input int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
      send_set(n);
      sent += n;
    end
  endtask

  // Drain: every predicted result back, then a short settle. Checked on the falling
  // edge so the checker's updates at the rising edge are already in. Ends on a rising edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_pct(input logic [P_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [P_W-1:0] pct_plan [10];
    pct_plan = '{14'd0, 14'd10000, 14'd16383, 14'd1, 14'd9999, 14'd10001, 14'd2500,
                 14'd7500, 14'd0, 14'd0};
    pct_plan[8] = P_W'($urandom_range(0, 16383));
    pct_plan[9] = P_W'($urandom_range(0, 10000));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed sets at the reset percentile (median): single-sample sets at both
    // extremes, the widest possible interpolation span, ties, alternating bit patterns.
    send_word(16'sh7fff, 1'b1);
    send_word(-16'sh8000, 1'b1);
    send_word(-16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh0000, 1'b0);
    send_word(-16'sh0001, 1'b0);
    send_word(16'sh0001, 1'b1);
    send_word(16'sh0005, 1'b0);
    send_word(-16'sh0003, 1'b0);
    send_word(16'sh5555, 1'b0);
    send_word(-16'sh5556, 1'b0);
    send_word(16'sh0007, 1'b1);
    send_word(16'sh0003, 1'b0);
    send_word(16'sh0003, 1'b0);
    send_word(16'sh0003, 1'b0);
    send_word(-16'sh0001, 1'b0);
    send_word(16'sh0003, 1'b1);
    drain();

    // Random phases, one percentile each: both ends of the range, values above
    // 10000 that must saturate, all-ones register, odd ranks. Every third phase
    // runs with no idling at all.
    for (int ph = 0; ph < 10; ph++) begin
      write_pct(pct_plan[ph]);
      steady = (ph % 3 == 2);
      run_sets(PHASE_WORDS);
      drain();
    end

    // Store filled to capacity with two words behind it, the last word itself
    // dropped, then a short set to see status clear again.
    steady = 1'b0;
    write_pct(14'd9000);
    send_set(CAPACITY + 2);
    send_set(3);
    drain();

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pli_pkg.sv
rtl/pli_div.sv
rtl/pli_sel.sv
rtl/percentile_linear_interp.sv
sim/pli_checker.sv
sim/tb_top.sv
